[design/ulg_pkg.sv]
`default_nettype none

package ulg_pkg;

	// Field and register widths.
	localparam int TICK_W    = 20;
	localparam int TRIG_W    = 16;
	localparam int SCALE_W   = 24;
	localparam int DIST_W    = 20;
	localparam int LEVEL_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int PROD_W    = TICK_W + SCALE_W;

	// Distance scaling: Q16 fraction, rounded to nearest.
	localparam int DIST_FRAC  = 16;
	localparam int DIST_ROUND = 32768;

	// Shared divider: remainder, dividend and iteration counter widths.
	localparam int DIV_REM_W   = 16;
	localparam int DIV_NUM_W   = 20;
	localparam int DIV_CNT_W   = 5;
	localparam int DIV_ITERS_AVG = 20;
	localparam int DIV_ITERS_LVL = 16;

	localparam int HISTORY_DEPTH_DEF = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CANISTER_H    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 3'd6;

	// Configuration values after reset.
	localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS = 16'd10;
	localparam logic [TICK_W-1:0]  RST_RISE_TIMEOUT  = 20'd50000;
	localparam logic [TICK_W-1:0]  RST_FALL_TIMEOUT  = 20'd500000;
	localparam logic [SCALE_W-1:0] RST_DIST_SCALE    = 24'd112394;
	localparam logic [LEVEL_W-1:0] RST_TOP_LEVEL     = 16'd1500;
	localparam logic [LEVEL_W-1:0] RST_CANISTER_H    = 16'd6600;
	localparam logic [LEVEL_W-1:0] RST_CAPACITY      = 16'd6000;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_MUL,
		OP_STORE,
		OP_AVG_INIT,
		OP_DIV_STEP,
		OP_AVG_DONE,
		OP_LVL_MUL,
		OP_LVL_INIT,
		OP_LVL_DONE,
		OP_EMIT
	} op_t;

	// Jump conditions; the jump is taken when the condition holds.
	typedef enum logic [3:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NO_BEAT,
		JC_NO_STORE,
		JC_CLEAN,
		JC_EMPTY,
		JC_DIV_MORE,
		JC_LVL_KNOWN,
		JC_OUT_BUSY
	} jc_t;

	typedef logic [3:0] pc_t;

	// Program addresses.
	localparam pc_t PC_TAKE     = 4'd0;
	localparam pc_t PC_MUL      = 4'd1;
	localparam pc_t PC_STORE    = 4'd2;
	localparam pc_t PC_CHECK    = 4'd3;
	localparam pc_t PC_AVG_INIT = 4'd4;
	localparam pc_t PC_AVG_DIV  = 4'd5;
	localparam pc_t PC_AVG_DONE = 4'd6;
	localparam pc_t PC_LVL_MUL  = 4'd7;
	localparam pc_t PC_LVL_INIT = 4'd8;
	localparam pc_t PC_LVL_DIV  = 4'd9;
	localparam pc_t PC_LVL_DONE = 4'd10;
	localparam pc_t PC_EMIT     = 4'd11;
	localparam pc_t PC_WRAP     = 4'd12;

	typedef struct packed {
		op_t op;
		jc_t jc;
		pc_t target;
	} ucode_t;

	// Datapath status seen by the sequencer's jump logic.
	typedef struct packed {
		logic beat;
		logic store;
		logic dirty;
		logic empty;
		logic div_more;
		logic lvl_known;
		logic out_busy;
	} dp_status_t;

	// Commands to the shared divider.
	typedef struct packed {
		logic load;
		logic step;
	} div_cmd_t;

	// The control program.
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_TAKE:     w = '{OP_TAKE,     JC_NO_BEAT,   PC_TAKE};
			PC_MUL:      w = '{OP_MUL,      JC_NO_STORE,  PC_CHECK};
			PC_STORE:    w = '{OP_STORE,    JC_NEXT,      PC_TAKE};
			PC_CHECK:    w = '{OP_NOP,      JC_CLEAN,     PC_EMIT};
			PC_AVG_INIT: w = '{OP_AVG_INIT, JC_EMPTY,     PC_AVG_DONE};
			PC_AVG_DIV:  w = '{OP_DIV_STEP, JC_DIV_MORE,  PC_AVG_DIV};
			PC_AVG_DONE: w = '{OP_AVG_DONE, JC_NEXT,      PC_TAKE};
			PC_LVL_MUL:  w = '{OP_LVL_MUL,  JC_NEXT,      PC_TAKE};
			PC_LVL_INIT: w = '{OP_LVL_INIT, JC_LVL_KNOWN, PC_LVL_DONE};
			PC_LVL_DIV:  w = '{OP_DIV_STEP, JC_DIV_MORE,  PC_LVL_DIV};
			PC_LVL_DONE: w = '{OP_LVL_DONE, JC_NEXT,      PC_TAKE};
			PC_EMIT:     w = '{OP_EMIT,     JC_OUT_BUSY,  PC_EMIT};
			PC_WRAP:     w = '{OP_NOP,      JC_ALWAYS,    PC_TAKE};
			default:     w = '{OP_NOP,      JC_ALWAYS,    PC_TAKE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[design/ulg_seq.sv]
`default_nettype none

module ulg_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ulg_pkg::dp_status_t st,
	output ulg_pkg::ucode_t         uc
);
	import ulg_pkg::*;

	pc_t  pc_q;
	logic taken;

	// Fetch the control word for the current step.
	assign uc = ucode_rom(pc_q);

	// Evaluate the jump condition of this step.
	always_comb begin
		unique case (uc.jc)
			JC_NEXT:      taken = 1'b0;
			JC_ALWAYS:    taken = 1'b1;
			JC_NO_BEAT:   taken = !st.beat;
			JC_NO_STORE:  taken = !st.store;
			JC_CLEAN:     taken = !st.dirty;
			JC_EMPTY:     taken = st.empty;
			JC_DIV_MORE:  taken = st.div_more;
			JC_LVL_KNOWN: taken = st.lvl_known;
			JC_OUT_BUSY:  taken = st.out_busy;
			default:      taken = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_TAKE;
		end else begin
			pc_q <= taken ? uc.target : pc_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

[design/ulg_div.sv]
`default_nettype none

module ulg_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ulg_pkg::div_cmd_t                    cmd,
	input  wire logic [ulg_pkg::DIV_CNT_W-1:0]        iters,
	input  wire logic [ulg_pkg::DIV_REM_W-1:0]        rem_init,
	input  wire logic [ulg_pkg::DIV_NUM_W-1:0]        num_lo,
	input  wire logic [ulg_pkg::DIV_REM_W-1:0]        divisor,
	output logic      [ulg_pkg::DIV_NUM_W-1:0]        quot,
	output logic                                      more
);
	import ulg_pkg::*;

	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_REM_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_REM_W:0]   trial;
	logic [DIV_REM_W:0]   diff;
	logic                 qbit;

	// One restoring step: bring down the next dividend bit and try the divisor.
	always_comb begin
		trial = {rem_q, num_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	assign quot = quot_q;
	assign more = (cnt_q > DIV_CNT_W'(1));

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= iters;
		end else if (cmd.step && cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// Remainder, dividend and quotient registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= rem_init;
			num_q  <= num_lo;
			den_q  <= divisor;
			quot_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= qbit ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
			num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_NUM_W-2:0], qbit};
		end
	end

endmodule

`default_nettype wire

[design/ulg_dp.sv]
`default_nettype none

module ulg_dp #(
	parameter int HISTORY_DEPTH = ulg_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ulg_pkg::ucode_t                   uc,
	output ulg_pkg::dp_status_t                    st,
	input  wire logic                              cfg_we,
	input  wire logic [ulg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ulg_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              start_req,
	input  wire logic                              echo,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   trigger,
	output logic                                   busy_res,
	output logic                                   done_res,
	output logic                                   timed_out,
	output logic      [ulg_pkg::DIST_W-1:0]        last_distance,
	output logic      [ulg_pkg::DIST_W-1:0]        avg_distance,
	output logic      [ulg_pkg::LEVEL_W-1:0]       level
);
	import ulg_pkg::*;

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = DIST_W + CNT_W;
	localparam int LNUM_W = DIST_W + 1;
	localparam int LPROD_W = 2 * LEVEL_W;

	typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_FALL} phase_t;

	// Configuration registers.
	logic [TRIG_W-1:0]  trig_ticks_q;
	logic [TICK_W-1:0]  rise_to_q;
	logic [TICK_W-1:0]  fall_to_q;
	logic [SCALE_W-1:0] scale_q;
	logic [LEVEL_W-1:0] top_q;
	logic [LEVEL_W-1:0] height_q;
	logic [LEVEL_W-1:0] cap_q;

	// Measurement control.
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d, tick_inc;
	logic              trig_d, done_d, tout_d, store_d;
	logic              beat;

	// Per-item flags held until the result is emitted.
	logic              it_trig_q, it_busy_q, it_done_q, it_tout_q, store_q;
	logic [TICK_W-1:0] width_q;

	// Reading ring and running mean.
	logic [DIST_W-1:0] hist_q [HISTORY_DEPTH];
	logic [DIST_W-1:0] old_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DIST_W-1:0] last_q;
	logic [DIST_W-1:0] avg_q;
	logic [LEVEL_W-1:0] level_q;
	logic              dirty_q;
	logic              full;

	// Distance scaling.
	logic [PROD_W-1:0]           dprod_q;
	logic [PROD_W:0]             dround;
	logic [PROD_W-DIST_FRAC:0]   dwide;
	logic [DIST_W-1:0]           dist_sat;

	// Level estimate.
	logic [LNUM_W-1:0]  lnum;
	logic [LEVEL_W-1:0] hdiv;
	logic               lzero, lsat;
	logic [LPROD_W-1:0] lprod_q;
	logic               lzero_q, lsat_q;

	// Divider hookup.
	div_cmd_t              div_cmd;
	logic [DIV_CNT_W-1:0]  div_iters;
	logic [DIV_REM_W-1:0]  div_rem;
	logic [DIV_NUM_W-1:0]  div_num;
	logic [DIV_REM_W-1:0]  div_den;
	logic [DIV_NUM_W-1:0]  div_quot;
	logic                  div_more;

	// Output register.
	logic               out_valid_q;
	logic               o_trig_q, o_busy_q, o_done_q, o_tout_q;
	logic [DIST_W-1:0]  o_last_q, o_avg_q;
	logic [LEVEL_W-1:0] o_level_q;
	logic               out_busy;

	assign in_ready = (uc.op == OP_TAKE);
	assign beat     = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(HISTORY_DEPTH));
	assign out_busy = out_valid_q && !out_ready;

	assign st = '{
		beat:      beat,
		store:     store_q,
		dirty:     dirty_q,
		empty:     (count_q == '0),
		div_more:  div_more,
		lvl_known: lzero_q || lsat_q,
		out_busy:  out_busy
	};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= RST_TRIGGER_TICKS;
			rise_to_q    <= RST_RISE_TIMEOUT;
			fall_to_q    <= RST_FALL_TIMEOUT;
			scale_q      <= RST_DIST_SCALE;
			top_q        <= RST_TOP_LEVEL;
			height_q     <= RST_CANISTER_H;
			cap_q        <= RST_CAPACITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIGGER_TICKS: trig_ticks_q <= cfg_data[TRIG_W-1:0];
				CFG_RISE_TIMEOUT:  rise_to_q    <= cfg_data[TICK_W-1:0];
				CFG_FALL_TIMEOUT:  fall_to_q    <= cfg_data[TICK_W-1:0];
				CFG_DIST_SCALE:    scale_q      <= cfg_data[SCALE_W-1:0];
				CFG_TOP_LEVEL:     top_q        <= cfg_data[LEVEL_W-1:0];
				CFG_CANISTER_H:    height_q     <= cfg_data[LEVEL_W-1:0];
				CFG_CAPACITY:      cap_q        <= cfg_data[LEVEL_W-1:0];
				default:           ;
			endcase
		end
	end

	// Next phase and tick count for one tick.
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		tick_inc = tick_q + TICK_W'(1);
		trig_d   = 1'b0;
		done_d   = 1'b0;
		tout_d   = 1'b0;
		store_d  = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					trig_d = 1'b1;
					if (trig_ticks_q <= TRIG_W'(1)) begin
						phase_d = PH_RISE;
						tick_d  = '0;
					end else begin
						phase_d = PH_TRIG;
						tick_d  = TICK_W'(1);
					end
				end
			end
			PH_TRIG: begin
				trig_d = 1'b1;
				if (tick_inc >= TICK_W'(trig_ticks_q)) begin
					phase_d = PH_RISE;
					tick_d  = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RISE: begin
				if (echo) begin
					phase_d = PH_FALL;
					tick_d  = TICK_W'(1);
				end else if (tick_q >= rise_to_q) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
					tout_d  = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_FALL: begin
				if (!echo) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
					store_d = 1'b1;
				end else if (tick_q >= fall_to_q) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					done_d  = 1'b1;
					tout_d  = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase
	end

	// Round the scaled width to hundredths of a centimetre and saturate.
	always_comb begin
		dround   = {1'b0, dprod_q} + (PROD_W + 1)'(DIST_ROUND);
		dwide    = dround[PROD_W:DIST_FRAC];
		dist_sat = (|dwide[PROD_W-DIST_FRAC:DIST_W]) ? '1 : dwide[DIST_W-1:0];
	end

	// Level numerator and its clamp cases; a zero height divides by one.
	always_comb begin
		hdiv  = (height_q == '0) ? LEVEL_W'(1) : height_q;
		lnum  = LNUM_W'(height_q) + LNUM_W'(top_q) - {1'b0, avg_q};
		lzero = lnum[LNUM_W-1] || (lnum == '0);
		lsat  = !lzero && (lnum[DIST_W-1:0] >= DIST_W'(hdiv));
	end

	// Divider operands for the mean and for the level.
	always_comb begin
		div_cmd   = '{load: 1'b0, step: 1'b0};
		div_iters = DIV_CNT_W'(DIV_ITERS_AVG);
		div_rem   = DIV_REM_W'(sum_q[SUM_W-1:DIST_W]);
		div_num   = sum_q[DIST_W-1:0];
		div_den   = DIV_REM_W'(count_q);
		unique case (uc.op)
			OP_AVG_INIT: begin
				div_cmd.load = (count_q != '0);
			end
			OP_LVL_INIT: begin
				div_cmd.load = !(lzero_q || lsat_q);
				div_iters    = DIV_CNT_W'(DIV_ITERS_LVL);
				div_rem      = lprod_q[LPROD_W-1:LEVEL_W];
				div_num      = {lprod_q[LEVEL_W-1:0], (DIV_NUM_W - LEVEL_W)'(0)};
				div_den      = hdiv;
			end
			OP_DIV_STEP: begin
				div_cmd.step = 1'b1;
			end
			default: ;
		endcase
	end

	ulg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.iters    (div_iters),
		.rem_init (div_rem),
		.num_lo   (div_num),
		.divisor  (div_den),
		.quot     (div_quot),
		.more     (div_more)
	);

	// Control state: phase, ring pointers, result cache and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			store_q     <= 1'b0;
			slot_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			last_q      <= '0;
			avg_q       <= '0;
			level_q     <= '0;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// A stored reading or a register write leaves the mean and level stale.
			if (cfg_we || uc.op == OP_STORE) begin
				dirty_q <= 1'b1;
			end else if (uc.op == OP_LVL_DONE) begin
				dirty_q <= 1'b0;
			end
			// The output beat is raised on emit and dropped once it is taken.
			if (uc.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (uc.op)
				OP_TAKE: begin
					if (beat) begin
						phase_q <= phase_d;
						tick_q  <= tick_d;
						store_q <= store_d;
					end
				end
				OP_STORE: begin
					if (full) begin
						sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(dist_sat);
					end else begin
						sum_q   <= sum_q + SUM_W'(dist_sat);
						count_q <= count_q + CNT_W'(1);
					end
					slot_q  <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 :
						slot_q + SLOT_W'(1);
					last_q  <= dist_sat;
				end
				OP_AVG_DONE: begin
					avg_q <= (count_q == '0) ? '0 : div_quot;
				end
				OP_LVL_INIT: begin
					if (lzero_q) begin
						level_q <= '0;
					end else if (lsat_q) begin
						level_q <= cap_q;
					end
				end
				OP_LVL_DONE: begin
					if (!(lzero_q || lsat_q)) begin
						level_q <= div_quot[LEVEL_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: item flags, products, ring storage and result fields.
	always_ff @(posedge clk) begin
		if (uc.op == OP_TAKE && beat) begin
			it_trig_q <= trig_d;
			it_busy_q <= (phase_d != PH_IDLE);
			it_done_q <= done_d;
			it_tout_q <= tout_d;
			width_q   <= tick_q;
		end
		if (uc.op == OP_MUL) begin
			dprod_q <= PROD_W'(width_q) * PROD_W'(scale_q);
			old_q   <= hist_q[slot_q];
		end
		if (uc.op == OP_STORE) begin
			hist_q[slot_q] <= dist_sat;
		end
		if (uc.op == OP_LVL_MUL) begin
			lprod_q <= LPROD_W'(cap_q) * LPROD_W'(lnum[LEVEL_W-1:0]);
			lzero_q <= lzero;
			lsat_q  <= lsat;
		end
		if (uc.op == OP_EMIT && !out_busy) begin
			o_trig_q  <= it_trig_q;
			o_busy_q  <= it_busy_q;
			o_done_q  <= it_done_q;
			o_tout_q  <= it_tout_q;
			o_last_q  <= last_q;
			o_avg_q   <= avg_q;
			o_level_q <= level_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger       = o_trig_q;
	assign busy_res      = o_busy_q;
	assign done_res      = o_done_q;
	assign timed_out     = o_tout_q;
	assign last_distance = o_last_q;
	assign avg_distance  = o_avg_q;
	assign level         = o_level_q;

endmodule

`default_nettype wire

[design/ultrasonic_level_gauge.sv]
// Ultrasonic level gauge: each input beat is one tick carrying a start request and the
// sampled echo level; each tick gives exactly one result beat with the trigger drive,
// busy, done and timeout flags, the latest stored distance, the floor mean of the last
// HISTORY_DEPTH readings and the remaining mass clamped to 0..capacity. A start while idle
// drives the trigger for trigger_ticks ticks, then the echo pulse is timed with separate
// rise and fall timeouts; a good width is scaled by distance_scale_q16 (Q16, rounded) to
// hundredths of a centimetre. A small microcoded sequencer runs the datapath. A tick that
// stores a reading, or the first tick after reset or after any configuration write,
// recomputes the mean and the level through one shared bit-serial divider (20 steps for
// the mean, 16 for the level); any other tick skips the divider. The result sits in an
// output register, so the next tick is taken while it waits. The user must write
// configuration only while idle; the block itself does not enforce it.
`default_nettype none

module ultrasonic_level_gauge #(
	parameter int HISTORY_DEPTH = ulg_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ulg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ulg_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              start_req,
	input  wire logic                              echo,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   trigger,
	output logic                                   busy_res,
	output logic                                   done_res,
	output logic                                   timed_out,
	output logic      [ulg_pkg::DIST_W-1:0]        last_distance,
	output logic      [ulg_pkg::DIST_W-1:0]        avg_distance,
	output logic      [ulg_pkg::LEVEL_W-1:0]       level
);
	import ulg_pkg::*;

	ucode_t     uc;
	dp_status_t st;

	// Control program sequencer.
	ulg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.uc     (uc)
	);

	// Measurement, ring, arithmetic and output register.
	ulg_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.uc            (uc),
		.st            (st),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_req     (start_req),
		.echo          (echo),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger       (trigger),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.timed_out     (timed_out),
		.last_distance (last_distance),
		.avg_distance  (avg_distance),
		.level         (level)
	);

endmodule

`default_nettype wire

[tb/sv/ultrasonic_level_gauge_tb.sv]
`timescale 1ns / 1ps

module ultrasonic_level_gauge_tb;
	import ulg_pkg::*;

	localparam int DEPTH           = HISTORY_DEPTH_DEF;
	localparam int IDLE_PCT        = 8;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 80;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_TICKS    = 1600;
	localparam int RANDOM_ROUNDS   = 8;
	localparam int MAX_REPORTS     = 10;
	localparam int LONG_TRIG       = 40;
	localparam int SUM_W           = DIST_W + $clog2(DEPTH);
	localparam int WPROD_W         = TICK_W + SCALE_W + 1;
	localparam logic [DIST_W-1:0] DIST_CEILING = '1;
	localparam logic [TICK_W-1:0] TICK_CEILING = '1;

	typedef enum logic [1:0] {
		MEAS_IDLE,
		MEAS_TRIG,
		MEAS_RISE,
		MEAS_FALL
	} meas_phase_t;

	typedef struct packed {
		logic              trigger;
		logic              busy;
		logic              done;
		logic              timed_out;
		logic [DIST_W-1:0] last_distance;
		logic [DIST_W-1:0] avg_distance;
		logic [LEVEL_W-1:0] level;
	} gauge_result_t;

	// Block ports.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 start_req = 1'b0;
	logic                 echo      = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 trigger;
	logic                 busy_res;
	logic                 done_res;
	logic                 timed_out;
	logic [DIST_W-1:0]    last_distance;
	logic [DIST_W-1:0]    avg_distance;
	logic [LEVEL_W-1:0]   level;

	// Traffic control shared by the stimulus and the receiver.
	bit steady        = 1'b0;
	bit stall_request = 1'b0;
	int stall_left    = 0;
	int ticks_sent    = 0;
	int beats_checked = 0;
	int fail_count    = 0;

	// Gauge configuration as the block should hold it.
	logic [TRIG_W-1:0]  trig_len;
	logic [TICK_W-1:0]  rise_lim;
	logic [TICK_W-1:0]  fall_lim;
	logic [SCALE_W-1:0] dist_scale;
	logic [LEVEL_W-1:0] top_mark;
	logic [LEVEL_W-1:0] can_height;
	logic [LEVEL_W-1:0] full_mass;

	// Measurement and history state of the gauge.
	meas_phase_t        gauge_phase;
	logic [TICK_W-1:0]  tick_cnt;
	logic [DIST_W-1:0]  ring [DEPTH];
	int unsigned        ring_slot;
	int unsigned        ring_fill;
	logic [SUM_W-1:0]   ring_sum;
	logic [DIST_W-1:0]  last_dist;

	gauge_result_t expected_results [$];
	gauge_result_t seen_beat;
	gauge_result_t want_beat;

	ultrasonic_level_gauge #(
		.HISTORY_DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_req    (start_req),
		.echo         (echo),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trigger      (trigger),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.timed_out    (timed_out),
		.last_distance(last_distance),
		.avg_distance (avg_distance),
		.level        (level)
	);

	always #2 clk = ~clk;

	// Gauge state after reset.
	task automatic reset_gauge_model();
		trig_len    = RST_TRIGGER_TICKS;
		rise_lim    = RST_RISE_TIMEOUT;
		fall_lim    = RST_FALL_TIMEOUT;
		dist_scale  = RST_DIST_SCALE;
		top_mark    = RST_TOP_LEVEL;
		can_height  = RST_CANISTER_H;
		full_mass   = RST_CAPACITY;
		gauge_phase = MEAS_IDLE;
		tick_cnt    = '0;
		ring_slot   = 0;
		ring_fill   = 0;
		ring_sum    = '0;
		last_dist   = '0;
		for (int i = 0; i < DEPTH; i++)
			ring[i] = '0;
	endtask

	function automatic logic [DIST_W-1:0] mean_of_ring();
		if (ring_fill == 0)
			return '0;
		return DIST_W'(ring_sum / ring_fill);
	endfunction

	// Remaining mass from the mean distance, clamped to 0..capacity.
	function automatic logic [LEVEL_W-1:0] mass_left(input logic [DIST_W-1:0] avg);
		longint num;
		longint unsigned divisor;
		longint unsigned mass;
		num = longint'(can_height) + longint'(top_mark) - longint'(avg);
		if (num <= 0)
			return '0;
		divisor = (can_height == '0) ? 64'd1 : 64'(can_height);
		mass = longint'(full_mass) * num;
		mass = mass / divisor;
		if (mass > full_mass)
			mass = 64'(full_mass);
		return mass[LEVEL_W-1:0];
	endfunction

	// Scale a pulse width to a distance and push it into the ring.
	task automatic store_width(input logic [TICK_W-1:0] width);
		logic [WPROD_W-1:0] prod;
		logic [DIST_W-1:0] reading;
		prod = WPROD_W'(width) * WPROD_W'(dist_scale) + WPROD_W'(DIST_ROUND);
		prod = prod >> DIST_FRAC;
		reading = (prod > WPROD_W'(DIST_CEILING)) ? DIST_CEILING : prod[DIST_W-1:0];
		if (ring_fill >= DEPTH)
			ring_sum -= SUM_W'(ring[ring_slot]);
		else
			ring_fill++;
		ring[ring_slot] = reading;
		ring_sum += SUM_W'(reading);
		ring_slot = (ring_slot + 1) % DEPTH;
		last_dist = reading;
	endtask

	// Advance the gauge by one tick and queue the result it gives.
	task automatic predict_tick(input logic start, input logic echo_hi);
		gauge_result_t r;
		r = '0;
		case (gauge_phase)
			MEAS_IDLE: begin
				if (start) begin
					r.trigger = 1'b1;
					tick_cnt = TICK_W'(1);
					if (tick_cnt >= trig_len) begin
						gauge_phase = MEAS_RISE;
						tick_cnt = '0;
					end else begin
						gauge_phase = MEAS_TRIG;
					end
				end
			end
			MEAS_TRIG: begin
				r.trigger = 1'b1;
				tick_cnt++;
				if (tick_cnt >= trig_len) begin
					gauge_phase = MEAS_RISE;
					tick_cnt = '0;
				end
			end
			MEAS_RISE: begin
				if (echo_hi) begin
					gauge_phase = MEAS_FALL;
					tick_cnt = TICK_W'(1);
				end else if (tick_cnt >= rise_lim) begin
					gauge_phase = MEAS_IDLE;
					tick_cnt = '0;
					r.done = 1'b1;
					r.timed_out = 1'b1;
				end else begin
					tick_cnt++;
				end
			end
			MEAS_FALL: begin
				if (!echo_hi) begin
					store_width(tick_cnt);
					gauge_phase = MEAS_IDLE;
					tick_cnt = '0;
					r.done = 1'b1;
				end else if (tick_cnt >= fall_lim) begin
					gauge_phase = MEAS_IDLE;
					tick_cnt = '0;
					r.done = 1'b1;
					r.timed_out = 1'b1;
				end else begin
					tick_cnt++;
				end
			end
		endcase
		r.busy = (gauge_phase != MEAS_IDLE);
		r.last_distance = last_dist;
		r.avg_distance = mean_of_ring();
		r.level = mass_left(r.avg_distance);
		expected_results.push_back(r);
	endtask

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", what);
	endtask

	// One result beat as text.
	function automatic string beat_text(input gauge_result_t b);
		return $sformatf("trig=%0b busy=%0b done=%0b tout=%0b last=%0d avg=%0d level=%0d",
			b.trigger, b.busy, b.done, b.timed_out, b.last_distance, b.avg_distance,
			b.level);
	endfunction

	// Offer one tick beat, with a random gap first, and predict it once taken.
	task automatic send_tick(input logic start, input logic echo_hi);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= start;
		echo      <= echo_hi;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		predict_tick(start, echo_hi);
		ticks_sent++;
	endtask

	// Stop offering and wait until every result beat has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all seven registers while the block is idle.
	task automatic set_config(input logic [TRIG_W-1:0] t_len, input logic [TICK_W-1:0] r_lim,
			input logic [TICK_W-1:0] f_lim, input logic [SCALE_W-1:0] scale,
			input logic [LEVEL_W-1:0] top, input logic [LEVEL_W-1:0] height,
			input logic [LEVEL_W-1:0] mass);
		logic [CFG_IDX_W-1:0] idx [7];
		logic [CFG_DAT_W-1:0] vals [7];
		int i;
		drain_results();
		idx = '{CFG_TRIGGER_TICKS, CFG_RISE_TIMEOUT, CFG_FALL_TIMEOUT, CFG_DIST_SCALE,
			CFG_TOP_LEVEL, CFG_CANISTER_H, CFG_CAPACITY};
		vals = '{CFG_DAT_W'(t_len), CFG_DAT_W'(r_lim), CFG_DAT_W'(f_lim), CFG_DAT_W'(scale),
			CFG_DAT_W'(top), CFG_DAT_W'(height), CFG_DAT_W'(mass)};
		for (i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		trig_len   = t_len;
		rise_lim   = r_lim;
		fall_lim   = f_lim;
		dist_scale = scale;
		top_mark   = top;
		can_height = height;
		full_mass  = mass;
	endtask

	// One measurement: settle to idle, start, then low and high echo stretches.
	task automatic run_measurement(input int lead, input int low_len, input int high_len);
		int k;
		while (gauge_phase != MEAS_IDLE)
			send_tick(1'b0, 1'b0);
		repeat (lead) send_tick(1'b0, 1'($urandom_range(0, 1)));
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (gauge_phase == MEAS_TRIG)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		for (k = 0; k < low_len && gauge_phase == MEAS_RISE; k++)
			send_tick(1'($urandom_range(0, 1)), 1'b0);
		for (k = 0; k < high_len && gauge_phase != MEAS_IDLE; k++)
			send_tick(1'($urandom_range(0, 1)), 1'b1);
		if (gauge_phase != MEAS_IDLE)
			send_tick(1'($urandom_range(0, 1)), 1'b0);
	endtask

	// Hand-picked ticks: ignored inputs, a good pulse and both timeouts.
	task automatic test_directed_cases();
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		// Start and echo mean nothing while the trigger is driven.
		while (gauge_phase == MEAS_TRIG)
			send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		repeat (3) send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		// A trigger length of zero still drives the pin for one tick.
		set_config('0, 2, 2, RST_DIST_SCALE, RST_TOP_LEVEL, RST_CANISTER_H, RST_CAPACITY);
		send_tick(1'b1, 1'b0);
		repeat (3) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		repeat (3) send_tick(1'b0, 1'b1);
	endtask

	// Register extremes: clamps, zero height, the widest scale and a long trigger.
	task automatic test_config_extremes();
		set_config(TRIG_W'(LONG_TRIG), TICK_CEILING, TICK_CEILING, '1, '1, '1, '1);
		run_measurement(0, 2, 1);
		run_measurement(1, 0, 60);
		set_config(1, 5, 5, '0, '0, '0, '0);
		repeat (DEPTH) run_measurement(0, 1, 2);
		// A zero canister height divides by one; the result clamps to capacity.
		set_config(1, 5, 5, '0, 5, '0, 3);
		run_measurement(0, 1, 2);
		// A mean beyond height plus top level gives an empty canister.
		set_config(1, 5, 10, '1, '0, 100, 100);
		run_measurement(0, 1, 5);
		set_config(TRIG_W'(LONG_TRIG), 3, 3, RST_DIST_SCALE, RST_TOP_LEVEL, RST_CANISTER_H,
			RST_CAPACITY);
		run_measurement(0, 1, 2);
	endtask

	// The receiver holds off while ticks keep coming, so the input stalls.
	task automatic test_output_stall();
		set_config(2, 6, 12, RST_DIST_SCALE, RST_TOP_LEVEL, RST_CANISTER_H, RST_CAPACITY);
		stall_request = 1'b1;
		repeat (6) run_measurement(0, 2, 3);
	endtask

	// Mostly well-formed measurements with random content, some noise between.
	task automatic test_random_traffic();
		int round;
		int first_tick;
		logic [TRIG_W-1:0] t_len;
		logic [SCALE_W-1:0] scale;
		logic [LEVEL_W-1:0] top;
		logic [LEVEL_W-1:0] height;
		for (round = 0; round < RANDOM_ROUNDS; round++) begin
			steady = (round == 3);
			t_len = (round == 0) ? '0 : TRIG_W'($urandom_range(1, 4));
			if (round % 2 == 1) begin
				scale  = SCALE_W'($urandom_range(20000, 300000));
				top    = LEVEL_W'($urandom_range(0, 3000));
				height = LEVEL_W'($urandom_range(2000, 20000));
			end else begin
				scale  = SCALE_W'($urandom_range(0, 24'hFFFFFF));
				top    = LEVEL_W'($urandom_range(0, 65535));
				height = (round == 6) ? '0 : LEVEL_W'($urandom_range(0, 65535));
			end
			set_config(t_len, TICK_W'($urandom_range(1, 12)), TICK_W'($urandom_range(1, 40)),
				scale, top, height, LEVEL_W'($urandom_range(0, 65535)));
			first_tick = ticks_sent;
			while (ticks_sent - first_tick < RANDOM_TICKS / RANDOM_ROUNDS) begin
				if ($urandom_range(0, 99) < 80)
					run_measurement($urandom_range(0, 3), $urandom_range(0, rise_lim + 1),
						$urandom_range(1, fall_lim + 1));
				else
					repeat ($urandom_range(1, 10))
						send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
		steady = 1'b0;
	endtask

	// Receiver: random ready, with a long hold-off on request.
	always @(posedge clk) begin
		if (stall_request) begin
			stall_request = 1'b0;
			stall_left = HOLD_OFF_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_beat = '{trigger, busy_res, done_res, timed_out, last_distance, avg_distance,
				level};
			if (expected_results.size() == 0) begin
				log_failure($sformatf("beat %0d unexpected: %s", beats_checked,
					beat_text(seen_beat)));
			end else begin
				want_beat = expected_results.pop_front();
				if (seen_beat !== want_beat)
					log_failure($sformatf("beat %0d mismatch: want %s, got %s",
						beats_checked, beat_text(want_beat), beat_text(seen_beat)));
			end
			beats_checked++;
		end
	end

	// Watchdog: give up when nothing has moved for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		reset_gauge_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_config_extremes();
		test_output_stall();
		test_random_traffic();
		drain_results();
		if (expected_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", expected_results.size()));
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
design/ulg_pkg.sv
design/ulg_seq.sv
design/ulg_div.sv
design/ulg_dp.sv
design/ultrasonic_level_gauge.sv
tb/sv/ultrasonic_level_gauge_tb.sv
